/* sv/wsst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package wsst_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int MIN_W       = 11;
    localparam int MIN_PER_HR  = 60;
    localparam int IN_W        = 48;
    localparam int OUT_W       = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic             is_tick;
        logic [3:0]       idx;
        logic [6:0]       mask;
        logic             one_shot;
        logic [MIN_W-1:0] start_min;
        logic [MIN_W-1:0] end_min;
        logic [2:0]       wd;
        logic [MIN_W-1:0] now_min;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic pend_v;
    } t_bk_stat;

    function automatic logic [MIN_W-1:0] to_minutes(input logic [4:0] h, input logic [5:0] m);
        to_minutes = MIN_W'(h) * MIN_W'(MIN_PER_HR) + MIN_W'(m);
    endfunction

endpackage
`default_nettype wire

/* sv/wsst_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module wsst_front (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire [wsst_pkg::IN_W-1:0]   i_s_axis_tdata,
    input  wire                        i_s_axis_tuser,
    output logic                       o_q_valid,
    output wsst_pkg::t_cmd             o_q_cmd,
    input  wire                        i_q_pop
);

    wsst_pkg::t_cmd r_q [wsst_pkg::QUEUE_DEPTH];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    wsst_pkg::t_cmd in_cmd;
    logic           push;
    logic           pop;

    always_comb begin
        in_cmd.is_tick   = (i_s_axis_tuser == wsst_pkg::OP_TICK);
        in_cmd.idx       = i_s_axis_tdata[3:0];
        in_cmd.mask      = i_s_axis_tdata[10:4];
        in_cmd.one_shot  = i_s_axis_tdata[11];
        in_cmd.start_min = wsst_pkg::to_minutes(i_s_axis_tdata[16:12], i_s_axis_tdata[22:17]);
        in_cmd.end_min   = wsst_pkg::to_minutes(i_s_axis_tdata[27:23], i_s_axis_tdata[33:28]);
        in_cmd.wd        = i_s_axis_tdata[36:34];
        in_cmd.now_min   = wsst_pkg::to_minutes(i_s_axis_tdata[41:37], i_s_axis_tdata[47:42]);
    end

    assign o_s_axis_tready = (r_cnt != 2'(wsst_pkg::QUEUE_DEPTH));
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_valid       = (r_cnt != 2'd0);
    assign pop             = i_q_pop && o_q_valid;
    assign o_q_cmd         = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= in_cmd;
    end

endmodule
`default_nettype wire

/* sv/wsst_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module wsst_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_q_valid,
    input  wsst_pkg::t_cmd             i_q_cmd,
    output logic                       o_q_pop,
    output logic                       o_m_axis_tvalid,
    input  wire                        i_m_axis_tready,
    output logic [wsst_pkg::OUT_W-1:0] o_m_axis_tdata,
    output logic                       o_m_axis_tlast,
    output wsst_pkg::t_bk_stat         o_stat
);

    localparam int N  = wsst_pkg::NUM_ENTRIES;
    localparam int IW = wsst_pkg::IDX_W;
    localparam int MW = wsst_pkg::MIN_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic          r_act   [N];
    logic          r_chan  [N];
    logic [6:0]    r_mask  [N];
    logic          r_one   [N];
    logic [MW-1:0] r_start [N];
    logic [MW-1:0] r_end   [N];

    logic [1:0]    r_state, n_state;
    logic [IW-1:0] r_ptr,   n_ptr;
    logic          r_pv,    n_pv;
    logic [IW-1:0] r_pidx,  n_pidx;
    logic          r_pon,   n_pon;
    logic          r_ov,    n_ov;
    logic [IW-1:0] r_oidx,  n_oidx;
    logic          r_oon,   n_oon;
    logic          r_olast, n_olast;
    logic [2:0]    r_wd;
    logic [MW-1:0] r_now;

    logic          wr;
    logic          upd;
    logic          latch;
    logic [IW-1:0] w_idx;
    logic [7:0]    mask_ext;
    logic          today;
    logic          ev_on;
    logic          ev_off;
    logic          ev;
    logic          out_free;

    assign w_idx    = IW'(i_q_cmd.idx);
    assign mask_ext = {1'b0, r_mask[r_ptr]};
    assign today    = r_act[r_ptr] && (r_one[r_ptr] || mask_ext[r_wd]);
    assign ev_on    = today && !r_chan[r_ptr] && (r_now >= r_start[r_ptr])
                      && (r_now < r_end[r_ptr]);
    assign ev_off   = today && r_chan[r_ptr] && (r_now > r_start[r_ptr])
                      && (r_now >= r_end[r_ptr]);
    assign ev       = ev_on || ev_off;
    assign out_free = !r_ov || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_pv    = r_pv;
        n_pidx  = r_pidx;
        n_pon   = r_pon;
        n_ov    = r_ov && !i_m_axis_tready;
        n_oidx  = r_oidx;
        n_oon   = r_oon;
        n_olast = r_olast;
        o_q_pop = 1'b0;
        wr      = 1'b0;
        upd     = 1'b0;
        latch   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.is_tick) begin
                        latch   = 1'b1;
                        n_ptr   = '0;
                        n_pv    = 1'b0;
                        n_state = S_WALK;
                    end else begin
                        wr = (32'(i_q_cmd.idx) < N);
                    end
                end
            end
            S_WALK: begin
                if (!(ev && r_pv && !out_free)) begin
                    upd = 1'b1;
                    if (ev) begin
                        if (r_pv) begin
                            n_ov    = 1'b1;
                            n_oidx  = r_pidx;
                            n_oon   = r_pon;
                            n_olast = 1'b0;
                        end
                        n_pv   = 1'b1;
                        n_pidx = r_ptr;
                        n_pon  = ev_on;
                    end
                    if (r_ptr == IW'(N - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_ov    = 1'b1;
                    n_oidx  = r_pidx;
                    n_oon   = r_pon;
                    n_olast = 1'b1;
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_act[i]  <= 1'b0;
                r_chan[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
            if (wr) begin
                r_act[w_idx]  <= 1'b1;
                r_chan[w_idx] <= 1'b0;
            end else if (upd && ev) begin
                r_chan[r_ptr] <= ev_on;
                if (ev_off && r_one[r_ptr]) r_act[r_ptr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_pidx  <= n_pidx;
        r_pon   <= n_pon;
        r_oidx  <= n_oidx;
        r_oon   <= n_oon;
        r_olast <= n_olast;
        if (latch) begin
            r_wd  <= i_q_cmd.wd;
            r_now <= i_q_cmd.now_min;
        end
        if (wr) begin
            r_mask[w_idx]  <= i_q_cmd.mask;
            r_one[w_idx]   <= i_q_cmd.one_shot;
            r_start[w_idx] <= i_q_cmd.start_min;
            r_end[w_idx]   <= i_q_cmd.end_min;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {3'b000, r_oon, 4'(r_oidx)};
    assign o_m_axis_tlast  = r_olast;
    assign o_stat.busy     = (r_state != S_IDLE);
    assign o_stat.pend_v   = r_pv;

endmodule
`default_nettype wire

/* sv/weekly_schedule_switch_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// Switch schedule table with 16 entries. A write transfer (tuser 0) loads one
// entry. A tick transfer (tuser 1) walks every entry, one per cycle unless the
// result side stalls, over the table's single read port; its events leave in
// index order, the final one with tlast set, and a tick that switches nothing
// gives no transfer. A two-deep queue in front accepts new transfers while a
// tick is still being walked.
module weekly_schedule_switch_table (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // entry_index, weekday_mask, one_shot, start_hour, start_minute,
    // end_hour, end_minute, now_weekday, now_hour, now_minute
    input  wire [wsst_pkg::IN_W-1:0]   i_s_axis_tdata,
    // operation
    input  wire                        i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire                        i_m_axis_tready,
    // switched_entry, switch_on, zero fill
    output logic [wsst_pkg::OUT_W-1:0] o_m_axis_tdata,
    output logic                       o_m_axis_tlast
);

    logic               q_valid;
    wsst_pkg::t_cmd     q_cmd;
    logic               q_pop;
    wsst_pkg::t_bk_stat bk_stat;

    wsst_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_q_valid       (q_valid),
        .o_q_cmd         (q_cmd),
        .i_q_pop         (q_pop)
    );

    wsst_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_cmd         (q_cmd),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_stat          (bk_stat)
    );

    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:5] == 3'b000))
        else $error("output fill bits not zero");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> (bk_stat.busy && bk_stat.pend_v))
        else $error("non-final event without a held event behind it");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !bk_stat.busy |-> !bk_stat.pend_v)
        else $error("held event left after tick walk");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bk_stat.busy && $past(bk_stat.busy)) |-> !q_pop)
        else $error("queue popped during tick walk");

endmodule
`default_nettype wire
